[rtl/core/tli_pkg.sv]
package tli_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int DATA_W      = 32;
    localparam int SIZE_W      = 7;
    localparam int IDX_OUT_W   = 7;
    localparam int ENTRY_IDX_W = 6;
    localparam int OOR_W       = 2;

    // Divider: top quotient bits are checked in one compare, the rest one bit a cycle
    localparam int DIV_STEPS = 34;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PROD_W    = 2 * DATA_W;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Range codes
    localparam logic [OOR_W-1:0] OOR_INSIDE = 2'd0;
    localparam logic [OOR_W-1:0] OOR_BELOW  = 2'd1;
    localparam logic [OOR_W-1:0] OOR_ABOVE  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CMP,
        S_PREP,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_ADD,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_MID
    } t_addr_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_BELOW,
        RES_ABOVE,
        RES_HIT_L,
        RES_HIT_RD,
        RES_FLAT,
        RES_SAT,
        RES_SUM
    } t_res_sel;

    typedef struct packed {
        logic      start_query;
        logic      wr_entry;
        logic      load_first;
        logic      load_last;
        logic      load_mid;
        logic      prep;
        logic      mul;
        logic      div_init;
        logic      div_step;
        logic      load_out;
        t_addr_sel addr_sel;
        t_res_sel  res_sel;
    } t_cmd;

    typedef struct packed {
        logic q_lt;
        logic q_gt;
        logic q_eq;
        logic eq_first;
        logic search_more;
        logic dx_zero;
        logic big;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/tli_ram.sv]
module tli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word, read one word with a registered output
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/tli_ctrl.sv]
module tli_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_operation,
    output logic          o_stall,
    input  tli_pkg::t_sts i_sts,
    output tli_pkg::t_cmd o_cmd
);

    tli_pkg::t_state r_state;
    tli_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tli_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            tli_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_operation == tli_pkg::OP_QUERY) begin
                        o_cmd.start_query = 1'b1;
                        o_cmd.addr_sel    = tli_pkg::ADDR_ZERO;
                        n_state           = tli_pkg::S_RD_FIRST;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            tli_pkg::S_RD_FIRST: begin
                o_cmd.load_first = 1'b1;
                o_cmd.addr_sel   = tli_pkg::ADDR_LAST;
                if (i_sts.q_lt) begin
                    o_cmd.res_sel = tli_pkg::RES_BELOW;
                    n_state       = tli_pkg::S_DONE;
                end else begin
                    n_state = tli_pkg::S_RD_LAST;
                end
            end
            tli_pkg::S_RD_LAST: begin
                o_cmd.load_last = 1'b1;
                o_cmd.addr_sel  = tli_pkg::ADDR_MID;
                if (i_sts.q_gt) begin
                    o_cmd.res_sel = tli_pkg::RES_ABOVE;
                    n_state       = tli_pkg::S_DONE;
                end else if (i_sts.eq_first) begin
                    o_cmd.res_sel = tli_pkg::RES_HIT_L;
                    n_state       = tli_pkg::S_DONE;
                end else if (i_sts.q_eq) begin
                    o_cmd.res_sel = tli_pkg::RES_HIT_RD;
                    n_state       = tli_pkg::S_DONE;
                end else if (i_sts.search_more) begin
                    n_state = tli_pkg::S_CMP;
                end else begin
                    n_state = tli_pkg::S_PREP;
                end
            end
            tli_pkg::S_CMP: begin
                o_cmd.load_mid = 1'b1;
                o_cmd.addr_sel = tli_pkg::ADDR_MID;
                if (i_sts.q_eq) begin
                    o_cmd.res_sel = tli_pkg::RES_HIT_RD;
                    n_state       = tli_pkg::S_DONE;
                end else if (i_sts.search_more) begin
                    n_state = tli_pkg::S_CMP;
                end else begin
                    n_state = tli_pkg::S_PREP;
                end
            end
            tli_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.dx_zero) begin
                    o_cmd.res_sel = tli_pkg::RES_FLAT;
                    n_state       = tli_pkg::S_DONE;
                end else begin
                    n_state = tli_pkg::S_MUL;
                end
            end
            tli_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = tli_pkg::S_DIV_INIT;
            end
            tli_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                if (i_sts.big) begin
                    o_cmd.res_sel = tli_pkg::RES_SAT;
                    n_state       = tli_pkg::S_DONE;
                end else begin
                    n_state = tli_pkg::S_DIV;
                end
            end
            tli_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = tli_pkg::S_ADD;
                end
            end
            tli_pkg::S_ADD: begin
                o_cmd.res_sel = tli_pkg::RES_SUM;
                n_state       = tli_pkg::S_DONE;
            end
            tli_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = tli_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tli_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_query_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation == tli_pkg::OP_QUERY)
        |=> r_state == tli_pkg::S_RD_FIRST)
        else $error("query request did not start the table read");

    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tli_pkg::S_DIV && !i_sts.div_done) |=> r_state == tli_pkg::S_DIV)
        else $error("divider left before its last step");

    a_result_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res_sel != tli_pkg::RES_NONE) |=> r_state == tli_pkg::S_DONE)
        else $error("result staged without going to the hand-off state");
`endif

endmodule

[rtl/core/tli_datapath.sv]
module tli_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [tli_pkg::SIZE_W-1:0]           i_cfg_wr_data,
    input  logic [tli_pkg::ENTRY_IDX_W-1:0]      i_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_entry_x,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_entry_y,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_query_value,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic signed [tli_pkg::DATA_W-1:0]    o_interpolated,
    output logic signed [tli_pkg::IDX_OUT_W-1:0] o_left_index,
    output logic signed [tli_pkg::IDX_OUT_W-1:0] o_right_index,
    output logic [tli_pkg::OOR_W-1:0]            o_out_of_range,
    output logic                                 o_saturated,
    input  tli_pkg::t_cmd                        i_cmd,
    output tli_pkg::t_sts                        o_sts
);

    localparam int DW  = tli_pkg::DATA_W;
    localparam int IW  = tli_pkg::IDX_W;
    localparam int OW  = tli_pkg::IDX_OUT_W;
    localparam int QW  = tli_pkg::DIV_STEPS;
    localparam int SW  = DW + 3;
    localparam logic [tli_pkg::SIZE_W-1:0] DEPTH_SZ = tli_pkg::SIZE_W'(tli_pkg::TABLE_DEPTH);
    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    // Configuration and query registers
    logic [tli_pkg::SIZE_W-1:0] r_table_size;
    logic signed [DW-1:0]       r_q;
    logic [IW-1:0]              r_n_last;
    logic [IW-1:0]              n_n_last;

    // Bracket registers
    logic [IW-1:0]        r_l;
    logic [IW-1:0]        r_r;
    logic [IW-1:0]        n_l;
    logic [IW-1:0]        n_r;
    logic signed [DW-1:0] r_xl;
    logic signed [DW-1:0] r_yl;
    logic signed [DW-1:0] r_xr;
    logic signed [DW-1:0] r_yr;
    logic                 r_eq_first;
    logic [IW-1:0]        r_rd_addr;
    logic [IW-1:0]        rd_addr;
    logic [IW:0]          mid_sum;
    logic [IW-1:0]        span;

    // Memory read side
    logic [2*DW-1:0]      rd_data;
    logic signed [DW-1:0] rd_x;
    logic signed [DW-1:0] rd_y;

    // Arithmetic registers
    logic [DW-1:0]                 r_mq;
    logic [DW-1:0]                 r_my;
    logic [DW-1:0]                 r_mx;
    logic                          r_neg;
    logic [tli_pkg::PROD_W-1:0]    r_prod;
    logic [DW-1:0]                 r_rem;
    logic [QW-1:0]                 r_dvd;
    logic [tli_pkg::CNT_W-1:0]     r_cnt;
    logic signed [DW:0]            dq;
    logic signed [DW:0]            dy;
    logic signed [DW:0]            dx;
    logic signed [DW:0]            dq_neg;
    logic signed [DW:0]            dy_neg;
    logic signed [DW:0]            dx_neg;
    logic [DW:0]                   trial;
    logic [DW:0]                   trial_diff;
    logic                          trial_ge;
    logic                          mag_over;
    logic signed [SW-1:0]          sum_term;
    logic signed [SW-1:0]          sum;
    logic                          sum_ovf;

    // Staged result and output register
    logic signed [DW-1:0]    r_res_val;
    logic signed [OW-1:0]    r_res_left;
    logic signed [OW-1:0]    r_res_right;
    logic [tli_pkg::OOR_W-1:0] r_res_oor;
    logic                    r_res_sat;
    logic                    r_out_valid;
    logic signed [DW-1:0]    r_out_val;
    logic signed [OW-1:0]    r_out_left;
    logic signed [OW-1:0]    r_out_right;
    logic [tli_pkg::OOR_W-1:0] r_out_oor;
    logic                    r_out_sat;

    // Table store: x in the upper half, y in the lower half
    tli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (tli_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_entry),
        .i_wr_addr (IW'(i_entry_index)),
        .i_wr_data ({i_entry_x, i_entry_y}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_x = rd_data[2*DW-1:DW];
    assign rd_y = rd_data[DW-1:0];

    // Clamp the entry count to the table and take its last index
    always_comb begin
        if (r_table_size == '0) begin
            n_n_last = '0;
        end else if (r_table_size > DEPTH_SZ) begin
            n_n_last = IW'(tli_pkg::TABLE_DEPTH - 1);
        end else begin
            n_n_last = IW'(r_table_size - tli_pkg::SIZE_W'(1));
        end
    end

    // Narrow the bracket after a probe
    always_comb begin
        n_l = r_l;
        n_r = r_r;
        if (i_cmd.load_last) begin
            n_r = r_n_last;
        end else if (i_cmd.load_mid) begin
            if (r_q == rd_x) begin
                n_l = r_rd_addr;
                n_r = r_rd_addr;
            end else if (r_q < rd_x) begin
                n_r = r_rd_addr;
            end else begin
                n_l = r_rd_addr;
            end
        end
    end

    assign mid_sum = {1'b0, n_l} + {1'b0, n_r};
    assign span    = n_r - n_l;

    // Choose the probe address
    always_comb begin
        unique case (i_cmd.addr_sel)
            tli_pkg::ADDR_ZERO: rd_addr = '0;
            tli_pkg::ADDR_LAST: rd_addr = r_n_last;
            tli_pkg::ADDR_MID:  rd_addr = mid_sum[IW:1];
            default:            rd_addr = '0;
        endcase
    end

    // Differences and magnitudes
    assign dq     = {r_q[DW-1], r_q} - {r_xl[DW-1], r_xl};
    assign dy     = {r_yr[DW-1], r_yr} - {r_yl[DW-1], r_yl};
    assign dx     = {r_xr[DW-1], r_xr} - {r_xl[DW-1], r_xl};
    assign dq_neg = -dq;
    assign dy_neg = -dy;
    assign dx_neg = -dx;

    // One restoring division step
    assign trial      = {r_rem, r_dvd[QW-1]};
    assign trial_ge   = trial >= {1'b0, r_mx};
    assign trial_diff = trial - {1'b0, r_mx};

    // Final add and clamp
    assign mag_over = r_dvd[QW-1] && (r_dvd[QW-2:0] != '0);
    assign sum_term = r_neg ? -SW'(r_dvd) : SW'(r_dvd);
    assign sum      = SW'(r_yl) + sum_term;
    assign sum_ovf  = (sum[SW-1:DW-1] != '0) && (sum[SW-1:DW-1] != '1);

    // Status to the controller
    always_comb begin
        o_sts.q_lt        = r_q < rd_x;
        o_sts.q_gt        = r_q > rd_x;
        o_sts.q_eq        = r_q == rd_x;
        o_sts.eq_first    = r_eq_first;
        o_sts.search_more = span > IW'(1);
        o_sts.dx_zero     = r_xr == r_xl;
        o_sts.big         = {2'b00, r_prod[tli_pkg::PROD_W-1:QW]} >= r_mx;
        o_sts.div_done    = r_cnt == tli_pkg::CNT_W'(QW - 1);
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    // Hold the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= tli_pkg::SIZE_W'(1);
        end else if (i_cfg_wr_en) begin
            r_table_size <= i_cfg_wr_data;
        end
    end

    // Capture the request and walk the bracket
    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        if (i_cmd.start_query) begin
            r_q      <= i_query_value;
            r_n_last <= n_n_last;
        end
        if (i_cmd.load_first) begin
            r_l        <= '0;
            r_xl       <= rd_x;
            r_yl       <= rd_y;
            r_eq_first <= r_q == rd_x;
        end
        if (i_cmd.load_last) begin
            r_r  <= n_r;
            r_xr <= rd_x;
            r_yr <= rd_y;
        end
        if (i_cmd.load_mid) begin
            r_l <= n_l;
            r_r <= n_r;
            if (r_q >= rd_x) begin
                r_xl <= rd_x;
                r_yl <= rd_y;
            end
            if (r_q <= rd_x) begin
                r_xr <= rd_x;
                r_yr <= rd_y;
            end
        end
    end

    // Magnitudes, product and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_mq  <= dq[DW] ? dq_neg[DW-1:0] : dq[DW-1:0];
            r_my  <= dy[DW] ? dy_neg[DW-1:0] : dy[DW-1:0];
            r_mx  <= dx[DW] ? dx_neg[DW-1:0] : dx[DW-1:0];
            r_neg <= dq[DW] ^ dy[DW] ^ dx[DW];
        end
        if (i_cmd.mul) begin
            r_prod <= r_mq * r_my;
        end
        if (i_cmd.div_init) begin
            r_rem <= DW'(r_prod[tli_pkg::PROD_W-1:QW]);
            r_dvd <= r_prod[QW-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
            r_dvd <= {r_dvd[QW-2:0], trial_ge};
            r_cnt <= r_cnt + tli_pkg::CNT_W'(1);
        end
    end

    // Stage the result
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.res_sel)
            tli_pkg::RES_NONE: begin
            end
            tli_pkg::RES_BELOW: begin
                r_res_val   <= '0;
                r_res_left  <= '1;
                r_res_right <= '0;
                r_res_oor   <= tli_pkg::OOR_BELOW;
                r_res_sat   <= 1'b0;
            end
            tli_pkg::RES_ABOVE: begin
                r_res_val   <= '0;
                r_res_left  <= OW'(r_n_last);
                r_res_right <= '1;
                r_res_oor   <= tli_pkg::OOR_ABOVE;
                r_res_sat   <= 1'b0;
            end
            tli_pkg::RES_HIT_L: begin
                r_res_val   <= r_yl;
                r_res_left  <= OW'(r_l);
                r_res_right <= OW'(r_l);
                r_res_oor   <= tli_pkg::OOR_INSIDE;
                r_res_sat   <= 1'b0;
            end
            tli_pkg::RES_HIT_RD: begin
                r_res_val   <= rd_y;
                r_res_left  <= OW'(r_rd_addr);
                r_res_right <= OW'(r_rd_addr);
                r_res_oor   <= tli_pkg::OOR_INSIDE;
                r_res_sat   <= 1'b0;
            end
            tli_pkg::RES_FLAT: begin
                r_res_val   <= r_yl;
                r_res_left  <= OW'(r_l);
                r_res_right <= OW'(r_r);
                r_res_oor   <= tli_pkg::OOR_INSIDE;
                r_res_sat   <= 1'b0;
            end
            tli_pkg::RES_SAT: begin
                r_res_val   <= r_neg ? VAL_MIN : VAL_MAX;
                r_res_left  <= OW'(r_l);
                r_res_right <= OW'(r_r);
                r_res_oor   <= tli_pkg::OOR_INSIDE;
                r_res_sat   <= 1'b1;
            end
            tli_pkg::RES_SUM: begin
                r_res_left  <= OW'(r_l);
                r_res_right <= OW'(r_r);
                r_res_oor   <= tli_pkg::OOR_INSIDE;
                if (mag_over) begin
                    r_res_val <= r_neg ? VAL_MIN : VAL_MAX;
                    r_res_sat <= 1'b1;
                end else if (sum_ovf) begin
                    r_res_val <= sum[SW-1] ? VAL_MIN : VAL_MAX;
                    r_res_sat <= 1'b1;
                end else begin
                    r_res_val <= sum[DW-1:0];
                    r_res_sat <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: load on hand-off, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_val   <= r_res_val;
            r_out_left  <= r_res_left;
            r_out_right <= r_res_right;
            r_out_oor   <= r_res_oor;
            r_out_sat   <= r_res_sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_interpolated = r_out_val;
    assign o_left_index   = r_out_left;
    assign o_right_index  = r_out_right;
    assign o_out_of_range = r_out_oor;
    assign o_saturated    = r_out_sat;

endmodule

[rtl/core/table_linear_interpolator_unit.sv]
// Piecewise linear interpolation over a 64-entry breakpoint table, Q16.16.
// Input channel (i_valid / o_stall): a write request (operation 0) stores
// entry_x and entry_y at entry_index and yields no result;
// a query request (operation 1) searches the first table_size entries for
// the bracketing pair and yields one result on the output channel.
// Output channel (o_valid / i_stall): interpolated value, bracket indices,
// range code and saturation flag, held in an output register.
// The work is a binary search (one table read per probe, up to six probes)
// and a restoring divider, 34 steps at one bit each.
// One query is worked at a time, so the next request is taken in the cycle
// after the result is loaded; a write does not hold the next request. A new
// request is taken while the previous result still sits in the output register.
// If the receiver stalls, the result is held and a finished query waits in
// its last step until the output register frees; o_stall stays high then.
// Reset clears the controller, empties the output register and sets
// table_size to 1; table contents are undefined until written.
module table_linear_interpolator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [tli_pkg::SIZE_W-1:0]           i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic [tli_pkg::ENTRY_IDX_W-1:0]      i_entry_index,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_entry_x,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_entry_y,
    input  logic signed [tli_pkg::DATA_W-1:0]    i_query_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [tli_pkg::DATA_W-1:0]    o_interpolated,
    output logic signed [tli_pkg::IDX_OUT_W-1:0] o_left_index,
    output logic signed [tli_pkg::IDX_OUT_W-1:0] o_right_index,
    output logic [tli_pkg::OOR_W-1:0]            o_out_of_range,
    output logic                                 o_saturated
);

    tli_pkg::t_cmd cmd;
    tli_pkg::t_sts sts;

    // Sequencer
    tli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table, search registers, divider and output register
    tli_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_entry_index  (i_entry_index),
        .i_entry_x      (i_entry_x),
        .i_entry_y      (i_entry_y),
        .i_query_value  (i_query_value),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_interpolated (o_interpolated),
        .o_left_index   (o_left_index),
        .o_right_index  (o_right_index),
        .o_out_of_range (o_out_of_range),
        .o_saturated    (o_saturated),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );

endmodule
